[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qdp check failed");

`define ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("qdp reset check failed");

`endif

[hdl/qdp_pkg.sv]
// Types and constants shared by the quantized dot product blocks
package qdp_pkg;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 31;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_MATRIX_ZP   = 2'd0,
    CFG_VECTOR_ZP   = 2'd1,
    CFG_SCALE_MULT  = 2'd2,
    CFG_SCALE_SHIFT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  matrix_zp;
    logic [7:0]  vector_zp;
    logic [30:0] scale_mult;
    logic [4:0]  scale_shift;
  } qdp_cfg_t;

  typedef struct packed {
    logic signed [8:0]  matrix_diff;
    logic signed [8:0]  vector_diff;
    logic [31:0]        row_bias;
    logic               first_of_row;
    logic               last_of_row;
  } qdp_work_t;

  typedef struct packed {
    logic [31:0] raw_sum;
    logic [7:0]  quantized_byte;
  } qdp_result_t;

  localparam int WorkW   = $bits(qdp_work_t);
  localparam int ResultW = $bits(qdp_result_t);

endpackage

[hdl/qdp_fifo.sv]
// Small register-based first-in first-out queue
module qdp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [Width-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [Width-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(Depth);

  logic [Width-1:0] mem_r [Depth];
  logic [AW:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]      rd_ptr_r, rd_ptr_nxt;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                   (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign rd_data = mem_r[rd_ptr_r[AW-1:0]];

  assign wr_ptr_nxt = (wr_en && !full)  ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = (rd_en && !empty) ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem_r[wr_ptr_r[AW-1:0]] <= wr_data;
    end
  end

endmodule

[hdl/qdp_front.sv]
// Input stage: accepts items and removes the zero points
module qdp_front import qdp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_matrix_byte,
  input  logic [7:0]  in_vector_byte,
  input  logic [31:0] in_row_bias,
  input  logic        in_first_of_row,
  input  logic        in_last_of_row,
  input  qdp_cfg_t    cfg,
  output qdp_work_t   work,
  output logic        work_valid,
  input  logic        work_full
);

  logic      valid_r, valid_nxt;
  qdp_work_t work_r;
  logic      accept;

  assign in_full    = valid_r && work_full;
  assign accept     = in_push && !in_full;
  assign valid_nxt  = accept || (valid_r && work_full);
  assign work       = work_r;
  assign work_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_r.matrix_diff  <= $signed({1'b0, in_matrix_byte}) - $signed({1'b0, cfg.matrix_zp});
      work_r.vector_diff  <= $signed({1'b0, in_vector_byte}) - $signed({1'b0, cfg.vector_zp});
      work_r.row_bias     <= in_row_bias;
      work_r.first_of_row <= in_first_of_row;
      work_r.last_of_row  <= in_last_of_row;
    end
  end

endmodule

[hdl/qdp_back.sv]
// Execution stage: accumulates products and requantizes row sums
module qdp_back import qdp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  qdp_work_t   work,
  input  logic        work_empty,
  output logic        work_pop,
  input  qdp_cfg_t    cfg,
  output qdp_result_t res,
  output logic        res_valid,
  input  logic        res_full
);

  logic               en;
  logic signed [17:0] prod;
  logic [31:0]        acc_base;
  logic [31:0]        acc_r, acc_nxt;

  logic               s1_v_r;
  logic [31:0]        s1_sum_r;
  logic               s2_v_r;
  logic               s2_neg_r;
  logic [31:0]        s2_mag_r;
  logic [31:0]        s2_sum_r;
  logic               s3_v_r;
  logic               s3_neg_r;
  logic [62:0]        s3_prod_r;
  logic [31:0]        s3_sum_r;

  logic [63:0]        rnd;
  logic [63:0]        quot;
  logic [5:0]         half_pos;
  logic [5:0]         shift_amt;

  assign en       = !(s3_v_r && res_full);
  assign work_pop = en && !work_empty;

  assign prod     = work.matrix_diff * work.vector_diff;
  assign acc_base = work.first_of_row ? work.row_bias : acc_r;
  assign acc_nxt  = acc_base + {{14{prod[17]}}, prod};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (work_pop) begin
        acc_r <= acc_nxt;
      end
      if (en) begin
        s1_v_r <= work_pop && work.last_of_row;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work_pop) begin
      s1_sum_r <= acc_nxt;
    end
    if (en) begin
      s2_neg_r  <= s1_sum_r[31];
      s2_mag_r  <= s1_sum_r[31] ? (~s1_sum_r + 32'd1) : s1_sum_r;
      s2_sum_r  <= s1_sum_r;
      s3_neg_r  <= s2_neg_r;
      s3_prod_r <= s2_mag_r * cfg.scale_mult;
      s3_sum_r  <= s2_sum_r;
    end
  end

  assign half_pos  = 6'd30 + {1'b0, cfg.scale_shift};
  assign shift_amt = 6'd31 + {1'b0, cfg.scale_shift};
  assign rnd       = {1'b0, s3_prod_r} + (64'd1 << half_pos);
  assign quot      = rnd >> shift_amt;

  always_comb begin
    res.raw_sum = s3_sum_r;
    if (s3_neg_r) begin
      res.quantized_byte = 8'd0;
    end else if (quot > 64'd255) begin
      res.quantized_byte = 8'd255;
    end else begin
      res.quantized_byte = quot[7:0];
    end
  end

  assign res_valid = s3_v_r;

endmodule

[hdl/quantized_dot_product_requant.sv]
// Top level of the quantized dot product with requantization
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   input    | in_push / in_full    | matrix_byte, vector_byte, row_bias, flags
//   result   | out_pop / out_empty  | raw_sum, quantized_byte
//   config   | cfg_wr_en            | cfg_index, cfg_data
//
// Sustains one item per cycle, and the accumulator one queued item per cycle, when unstalled.
// A row's last item passes the front register, work queue, s1, s2, s3, then the result queue.
// Reset is synchronous and empties both queues; control and config registers return to their defaults.
// A full result queue holds the requantize pipeline, then the work queue, then in_full.
module quantized_dot_product_requant import qdp_pkg::*; #(
  parameter int QUEUE_DEPTH  = 4,
  parameter int RESULT_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [7:0]          in_matrix_byte,
  input  logic [7:0]          in_vector_byte,
  input  logic signed [31:0]  in_row_bias,
  input  logic                in_first_of_row,
  input  logic                in_last_of_row,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [31:0]  out_raw_sum,
  output logic [7:0]          out_quantized_byte,
  input  logic                cfg_wr_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam logic [30:0] ScaleMultReset = 31'd1073741824;

  qdp_cfg_t    cfg_r;
  qdp_work_t   front_work;
  logic        front_valid;
  logic        work_full;
  qdp_work_t   queue_work;
  logic        work_empty;
  logic        work_pop;
  qdp_result_t back_res;
  logic        back_valid;
  logic        res_full;
  qdp_result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.matrix_zp   <= 8'd0;
      cfg_r.vector_zp   <= 8'd0;
      cfg_r.scale_mult  <= ScaleMultReset;
      cfg_r.scale_shift <= 5'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_MATRIX_ZP:   cfg_r.matrix_zp   <= cfg_data[7:0];
        CFG_VECTOR_ZP:   cfg_r.vector_zp   <= cfg_data[7:0];
        CFG_SCALE_MULT:  cfg_r.scale_mult  <= cfg_data[30:0];
        CFG_SCALE_SHIFT: cfg_r.scale_shift <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  qdp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_matrix_byte  (in_matrix_byte),
    .in_vector_byte  (in_vector_byte),
    .in_row_bias     (in_row_bias),
    .in_first_of_row (in_first_of_row),
    .in_last_of_row  (in_last_of_row),
    .cfg             (cfg_r),
    .work            (front_work),
    .work_valid      (front_valid),
    .work_full       (work_full)
  );

  qdp_fifo #(
    .Width (WorkW),
    .Depth (QUEUE_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_valid),
    .wr_data (front_work),
    .full    (work_full),
    .rd_en   (work_pop),
    .rd_data (queue_work),
    .empty   (work_empty)
  );

  qdp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .work       (queue_work),
    .work_empty (work_empty),
    .work_pop   (work_pop),
    .cfg        (cfg_r),
    .res        (back_res),
    .res_valid  (back_valid),
    .res_full   (res_full)
  );

  qdp_fifo #(
    .Width (ResultW),
    .Depth (RESULT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (back_valid),
    .wr_data (back_res),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (out_res),
    .empty   (out_empty)
  );

  assign out_raw_sum        = out_res.raw_sum;
  assign out_quantized_byte = out_res.quantized_byte;

endmodule

[hdl/qdp_checker.sv]
// Port-level checks for the quantized dot product top level
`include "assert_macros.svh"

module qdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_raw_sum,
  input logic [7:0]  out_quantized_byte
);

  `ASSERT_RST(a_reset_empty, clk, !rst_n |=> out_empty)
  `ASSERT_RST(a_reset_ready, clk, !rst_n |=> !in_full)
  `ASSERT_CLK(a_neg_to_zero, clk, rst_n, (!out_empty && out_raw_sum[31]) |-> (out_quantized_byte == 8'd0))
  `ASSERT_CLK(a_zero_sum, clk, rst_n, (!out_empty && (out_raw_sum == 32'd0)) |-> (out_quantized_byte == 8'd0))
  `ASSERT_CLK(a_hold, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_raw_sum)))

endmodule

bind quantized_dot_product_requant qdp_checker u_qdp_checker (.*);

[dv/quantized_dot_product_requant_tb.sv]
// Testbench for quantized_dot_product_requant: directed and random rows checked against a predictor
`timescale 1ns / 1ps

module quantized_dot_product_requant_tb;
  import qdp_pkg::*;

  localparam int SettleCycles = 12;
  localparam int ItemsPerPhase = 230;

  typedef struct {
    logic [7:0]         matrix_byte;
    logic [7:0]         vector_byte;
    logic signed [31:0] row_bias;
    logic               first_of_row;
    logic               last_of_row;
  } dot_item_t;

  typedef struct {
    logic signed [31:0] raw_sum;
    logic [7:0]         quantized_byte;
  } row_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [7:0]           in_matrix_byte;
  logic [7:0]           in_vector_byte;
  logic signed [31:0]   in_row_bias;
  logic                 in_first_of_row;
  logic                 in_last_of_row;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic signed [31:0]   out_raw_sum;
  logic [7:0]           out_quantized_byte;
  logic                 cfg_wr_en;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  logic [7:0]  zp_matrix = 8'd0;
  logic [7:0]  zp_vector = 8'd0;
  logic [30:0] q_mult = 31'd1073741824;
  logic [4:0]  q_shift = 5'd0;
  logic [31:0] dot_acc = 32'd0;

  row_result_t pending_rows[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  quantized_dot_product_requant i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_matrix_byte    (in_matrix_byte),
    .in_vector_byte    (in_vector_byte),
    .in_row_bias       (in_row_bias),
    .in_first_of_row   (in_first_of_row),
    .in_last_of_row    (in_last_of_row),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_raw_sum       (out_raw_sum),
    .out_quantized_byte(out_quantized_byte),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAIL quantized_dot_product_requant");
    $finish;
  end

  function automatic logic [7:0] requantize_sum(logic [31:0] sum);
    logic [63:0] scaled;
    int          sh;
    if (sum[31]) return 8'd0;
    sh = 31 + int'(q_shift);
    scaled = {32'd0, sum} * {33'd0, q_mult};
    scaled = (scaled + (64'd1 << (sh - 1))) >> sh;
    return (scaled > 64'd255) ? 8'd255 : scaled[7:0];
  endfunction

  task automatic accumulate_pair(dot_item_t it);
    int          diff_m;
    int          diff_v;
    row_result_t r;
    diff_m = int'(it.matrix_byte) - int'(zp_matrix);
    diff_v = int'(it.vector_byte) - int'(zp_vector);
    if (it.first_of_row) dot_acc = it.row_bias;
    dot_acc = dot_acc + diff_m * diff_v;
    if (it.last_of_row) begin
      r.raw_sum = dot_acc;
      r.quantized_byte = requantize_sum(dot_acc);
      pending_rows.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got 0x%08h want 0x%08h", $time, what, got, want);
    mismatches++;
  endtask

  // receiver: random stalls, plus a counted hold-off on request
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_pop <= 1'b0;
      hold_off_cycles--;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    row_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("result with no row pending", out_raw_sum, 32'd0);
      end else begin
        want = pending_rows.pop_front();
        if (out_raw_sum !== want.raw_sum)
          report_mismatch("raw_sum", out_raw_sum, want.raw_sum);
        if (out_quantized_byte !== want.quantized_byte)
          report_mismatch("quantized_byte", {24'd0, out_quantized_byte},
                          {24'd0, want.quantized_byte});
      end
    end
  end

  task automatic send_item(dot_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push         <= 1'b1;
    in_matrix_byte  <= it.matrix_byte;
    in_vector_byte  <= it.vector_byte;
    in_row_bias     <= it.row_bias;
    in_first_of_row <= it.first_of_row;
    in_last_of_row  <= it.last_of_row;
    @(posedge clk);
    while (in_full) @(posedge clk);
    accumulate_pair(it);
  endtask

  task automatic send_pair(logic [7:0] mb, logic [7:0] vb, logic [31:0] bias,
                           logic first, logic last);
    dot_item_t it;
    it.matrix_byte = mb;
    it.vector_byte = vb;
    it.row_bias = bias;
    it.first_of_row = first;
    it.last_of_row = last;
    send_item(it);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CfgDataW-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] mzp, logic [7:0] vzp, logic [30:0] mult,
                            logic [4:0] shift);
    drain();
    write_reg(CFG_MATRIX_ZP, {23'd0, mzp});
    write_reg(CFG_VECTOR_ZP, {23'd0, vzp});
    write_reg(CFG_SCALE_MULT, mult);
    write_reg(CFG_SCALE_SHIFT, {26'd0, shift});
    cfg_wr_en <= 1'b0;
    zp_matrix = mzp;
    zp_vector = vzp;
    q_mult = mult;
    q_shift = shift;
  endtask

  function automatic dot_item_t random_item();
    dot_item_t it;
    it.matrix_byte = 8'($urandom_range(255));
    it.vector_byte = 8'($urandom_range(255));
    it.first_of_row = 1'($urandom_range(1));
    it.last_of_row = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: it.row_bias = $urandom_range(4000) - 2000;
      1: it.row_bias = $urandom();
      2: begin
        case ($urandom_range(3))
          0: it.row_bias = 32'h7FFF_FFFF;
          1: it.row_bias = 32'h8000_0000;
          2: it.row_bias = 32'hFFFF_FFFF;
          default: it.row_bias = 32'h0000_0000;
        endcase
      end
      default: it.row_bias = $urandom_range(2 ** 21) - 2 ** 20;
    endcase
    return it;
  endfunction

  task automatic send_row(int len);
    dot_item_t it;
    for (int k = 0; k < len; k++) begin
      it = random_item();
      // keep most rows well formed, leave the rest with random flags
      if ($urandom_range(9) != 0) begin
        it.first_of_row = (k == 0);
        it.last_of_row = (k == len - 1);
      end
      send_item(it);
    end
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  task automatic test_directed_cases();
    set_idling(0, 0);
    // reset defaults: half scale, no shift, zero points at zero
    send_pair(8'd255, 8'd255, 32'd0, 1'b1, 1'b1);
    send_pair(8'd3, 8'd1, 32'd0, 1'b1, 1'b1);
    send_pair(8'd0, 8'd0, 32'd10, 1'b1, 1'b0);
    send_pair(8'd1, 8'd1, 32'h7FFF_FFFF, 1'b0, 1'b1);
    send_pair(8'd2, 8'd2, 32'h8000_0000, 1'b0, 1'b1);
    send_pair(8'd0, 8'd0, -32'sd100, 1'b1, 1'b1);
    send_pair(8'd255, 8'd255, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_pair(8'd0, 8'd0, 32'h8000_0000, 1'b1, 1'b1);
    send_pair(8'd1, 8'd1, 32'hFFFF_FFFF, 1'b1, 1'b1);
    set_config(8'd255, 8'd0, 31'h7FFF_FFFF, 5'd31);
    send_pair(8'd0, 8'd255, 32'd0, 1'b1, 1'b1);
    send_pair(8'd0, 8'd0, 32'h7FFF_FFFF, 1'b1, 1'b1);
    set_config(8'd0, 8'd255, 31'h7FFF_FFFF, 5'd0);
    send_pair(8'd255, 8'd0, 32'd70000, 1'b1, 1'b1);
    send_pair(8'd0, 8'd9, 32'd100, 1'b1, 1'b1);
    set_config(8'd128, 8'd128, 31'd0, 5'd31);
    send_pair(8'd255, 8'd255, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_pair(8'd0, 8'd0, 32'd0, 1'b1, 1'b1);
    set_config(8'd255, 8'd255, 31'd1073741824, 5'd1);
    send_pair(8'd0, 8'd0, -32'sd65024, 1'b1, 1'b1);
    send_pair(8'd255, 8'd255, 32'd6, 1'b1, 1'b1);
    send_pair(8'd0, 8'd0, 32'd1, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_random_rows();
    int sent;
    int row_len;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: set_config(8'd255, 8'd255, 31'h7FFF_FFFF, 5'd31);
        2: set_config(8'd0, 8'd0, 31'd0, 5'd0);
        5: set_config(8'd0, 8'd0, 31'h7FFF_FFFF, 5'd0);
        default: set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                            31'($urandom()), 5'($urandom_range(31)));
      endcase
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(72, 0);
        2: set_idling(0, 72);
        default: set_idling(6, 6);
      endcase
      sent = 0;
      while (sent < ItemsPerPhase) begin
        row_len = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
        send_row(row_len);
        sent += row_len;
      end
    end
    set_idling(0, 0);
    drain();
  endtask

  task automatic test_result_backpressure();
    set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
               31'($urandom()), 5'($urandom_range(8)));
    set_idling(0, 0);
    hold_off_cycles = 300;
    repeat (48) send_row(1);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_matrix_byte = 8'd0;
    in_vector_byte = 8'd0;
    in_row_bias = 32'sd0;
    in_first_of_row = 1'b0;
    in_last_of_row = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_MATRIX_ZP;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_rows();
    test_result_backpressure();
    drain();
    if (mismatches == 0) begin
      $display("PASS quantized_dot_product_requant");
    end else begin
      $display("FAIL quantized_dot_product_requant");
    end
    $finish;
  end

endmodule

[quantized_dot_product_requant.f]
+incdir+hdl
hdl/qdp_pkg.sv
hdl/qdp_fifo.sv
hdl/qdp_front.sv
hdl/qdp_back.sv
hdl/quantized_dot_product_requant.sv
hdl/qdp_checker.sv
dv/quantized_dot_product_requant_tb.sv
